[src/assert_macros.svh]
// Assertion macros shared by the sphere vertex generator RTL.
// Bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, c)
`define ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

[src/uvsph_pkg.sv]
// Package for the UV sphere vertex generator: constants, payload types and
// the per-cell state of the division chain. No dependencies.
package uvsph_pkg;
	localparam int MAX_RINGS_DEF   = 256;
	localparam int MAX_SECTORS_DEF = 256;
	localparam int DIV_BITS        = 24;
	localparam int SINE_STAGES     = 5;
	localparam int PIPE_DEPTH      = DIV_BITS + SINE_STAGES + 2;
	localparam logic [16:0] COEF_A = 17'd102944;
	localparam logic [15:0] COEF_B = 16'd42047;
	localparam logic [12:0] COEF_C = 13'd4639;
	localparam logic [15:0] QUARTER = 16'd16384;

	typedef enum logic [1:0] {
		REG_RADIUS = 2'd0,
		REG_RINGS  = 2'd1,
		REG_SECTORS = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] ring_index;
		logic [7:0] sector_index;
	} in_item_t;

	typedef struct packed {
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_z;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
		logic [15:0] corner_a;
		logic [15:0] corner_b;
		logic [15:0] corner_c;
		logic [15:0] corner_d;
		logic        quad_valid;
	} out_item_t;

	// Per-item data that every cell of the chain carries forward.
	typedef struct packed {
		logic        vld;
		logic [7:0]  r;
		logic [7:0]  s;
		logic [8:0]  rd;       // rings - 1
		logic [8:0]  sd;       // sectors - 1
		logic [8:0]  sectors;
		logic [15:0] radius;
	} cell_ctl_t;

	// Partial state of the polar and azimuth divisions between two cells.
	typedef struct packed {
		logic [23:0] num_p;
		logic [23:0] num_a;
		logic [7:0]  rem_p;
		logic [7:0]  rem_a;
		logic [15:0] quo_p;
		logic [15:0] quo_a;
	} div_st_t;
endpackage

[src/uvsph_if.sv]
// Valid/ready stream interface carrying one payload beat.
// Depends on nothing but its type parameter.
interface uvsph_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/uvsph_div_cell.sv]
// One restoring-division cell: produces one quotient bit of the two phase
// divisions per cycle while en is high and hands the partial state to the next cell.
// Depends on uvsph_pkg.
module uvsph_div_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  uvsph_pkg::cell_ctl_t  ctl_in,
	input  uvsph_pkg::div_st_t    div_in,
	output uvsph_pkg::cell_ctl_t  ctl_q,
	output uvsph_pkg::div_st_t    div_q
);
	import uvsph_pkg::*;
	logic [8:0] tp, ta;
	logic gp, ga;
	always_comb begin
		tp = {div_in.rem_p, div_in.num_p[23]};
		ta = {div_in.rem_a, div_in.num_a[23]};
		gp = (tp >= ctl_in.rd);
		ga = (ta >= ctl_in.sd);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end
	// Only the low 16 quotient bits are kept, which wraps the phase to a turn.
	always_ff @(posedge clk) begin
		if (en) begin
			div_q.num_p <= {div_in.num_p[22:0], 1'b0};
			div_q.num_a <= {div_in.num_a[22:0], 1'b0};
			div_q.rem_p <= gp ? 8'(tp - ctl_in.rd) : tp[7:0];
			div_q.rem_a <= ga ? 8'(ta - ctl_in.sd) : ta[7:0];
			div_q.quo_p <= {div_in.quo_p[14:0], gp};
			div_q.quo_a <= {div_in.quo_a[14:0], ga};
		end
	end
endmodule

[src/uvsph_sine.sv]
// Pipelined quarter-wave sine of a 16-bit phase, Q1.14 out.
// Uses uvsph_pkg coefficients.
module uvsph_sine (
	input  logic                clk,
	input  logic                en,
	input  logic [15:0]         phase,
	output logic signed [15:0]  sine
);
	import uvsph_pkg::*;
	logic [14:0] t_s1;
	logic        neg_s1, neg_s2, neg_s3, neg_s4;
	logic [14:0] t_s2, t_s3;
	logic [14:0] t2_s2, t2_s3;
	logic [15:0] inner_s3;
	logic [16:0] mid_s4;
	logic [14:0] t_s4;
	logic [14:0] f;
	logic [29:0] sq;
	logic [27:0] pc;
	logic [30:0] pm;
	logic [31:0] pf;
	always_comb begin
		f  = {1'b0, phase[13:0]};
		sq = t_s1 * t_s1;
		pc = t2_s2 * COEF_C;
		pm = t2_s3 * inner_s3;
		pf = t_s4 * mid_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			t_s1   <= phase[14] ? 15'(QUARTER - 16'(f)) : f;
			neg_s1 <= phase[15];
			t_s2 <= t_s1; neg_s2 <= neg_s1; t2_s2 <= sq[28:14];
			t_s3 <= t_s2; neg_s3 <= neg_s2; t2_s3 <= t2_s2;
			inner_s3 <= 16'(COEF_B - 16'(pc[27:14]));
			t_s4 <= t_s3; neg_s4 <= neg_s3;
			mid_s4 <= 17'(COEF_A - 17'(pm[30:14]));
			sine <= neg_s4 ? -$signed({1'b0, pf[30:16]}) : $signed({1'b0, pf[30:16]});
		end
	end
endmodule

[src/uvsph_core.sv]
// Chain of division cells followed by sine, normal and position stages.
// Depends on uvsph_pkg, uvsph_div_cell and uvsph_sine.
module uvsph_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  uvsph_pkg::cell_ctl_t  ctl_in,
	output uvsph_pkg::cell_ctl_t  ctl_out,
	output uvsph_pkg::out_item_t  res
);
	import uvsph_pkg::*;
	cell_ctl_t ctl_c [DIV_BITS+1];
	div_st_t   div_c [DIV_BITS+1];
	logic [15:0] pol, az;
	logic signed [15:0] sp, cp, sa, ca;
	cell_ctl_t dl_q [SINE_STAGES];
	logic signed [31:0] px, pz;
	logic signed [15:0] nx_s1, ny_s1, nz_s1;
	cell_ctl_t n_s1, o_s2;
	logic signed [33:0] mx, my, mz;
	logic [16:0] base, base1;
	logic q_ok;

	// The first cell sees the numerators with half the divisor added for rounding.
	assign ctl_c[0] = ctl_in;
	assign div_c[0] = {24'({ctl_in.r, 15'd0}) + 24'(ctl_in.rd[8:1]),
		24'({ctl_in.s, 16'd0}) + 24'(ctl_in.sd[8:1]), 8'd0, 8'd0, 16'd0, 16'd0};

	for (genvar i = 0; i < DIV_BITS; i++) begin : g_div
		uvsph_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.ctl_in(ctl_c[i]), .div_in(div_c[i]),
			.ctl_q(ctl_c[i+1]), .div_q(div_c[i+1])
		);
	end

	assign pol = div_c[DIV_BITS].quo_p;
	assign az  = div_c[DIV_BITS].quo_a;

	uvsph_sine u_sp (.clk(clk), .en(en), .phase(pol), .sine(sp));
	uvsph_sine u_cp (.clk(clk), .en(en), .phase(16'(pol + QUARTER)), .sine(cp));
	uvsph_sine u_sa (.clk(clk), .en(en), .phase(az), .sine(sa));
	uvsph_sine u_ca (.clk(clk), .en(en), .phase(16'(az + QUARTER)), .sine(ca));

	// Delay control alongside the sine stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < SINE_STAGES; d++)
				dl_q[d] <= '0;
		end else if (en) begin
			dl_q[0] <= ctl_c[DIV_BITS];
			for (int d = 1; d < SINE_STAGES; d++)
				dl_q[d] <= dl_q[d-1];
		end
	end

	// Normal stage.
	always_comb begin
		px = ca * sp + 32'sd8192;
		pz = sa * sp + 32'sd8192;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_s1 <= '0;
			o_s2 <= '0;
		end else if (en) begin
			n_s1 <= dl_q[SINE_STAGES-1];
			o_s2 <= n_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			nx_s1 <= px[29:14];
			ny_s1 <= -cp;
			nz_s1 <= pz[29:14];
		end
	end
	// Position and corner stage.
	always_comb begin
		mx = nx_s1 * $signed({1'b0, n_s1.radius}) + 34'sd128;
		my = ny_s1 * $signed({1'b0, n_s1.radius}) + 34'sd128;
		mz = nz_s1 * $signed({1'b0, n_s1.radius}) + 34'sd128;
		base  = 17'(n_s1.r * n_s1.sectors) + 17'(n_s1.s);
		base1 = 17'(base + 17'(n_s1.sectors));
		q_ok = ({1'b0, n_s1.r} < n_s1.rd) && ({1'b0, n_s1.s} < n_s1.sd);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			res.pos_x <= mx[31:8];
			res.pos_y <= my[31:8];
			res.pos_z <= mz[31:8];
			res.norm_x <= nx_s1;
			res.norm_y <= ny_s1;
			res.norm_z <= nz_s1;
			res.corner_a <= q_ok ? base[15:0] : 16'd0;
			res.corner_b <= q_ok ? 16'(base + 17'd1) : 16'd0;
			res.corner_c <= q_ok ? 16'(base1 + 17'd1) : 16'd0;
			res.corner_d <= q_ok ? base1[15:0] : 16'd0;
			res.quad_valid <= q_ok;
		end
	end
	assign ctl_out = o_s2;
endmodule

[src/uv_sphere_vertex_generator_top.sv]
// Channel | dir | payload
// in_ch   | in  | ring_index, sector_index
// out_ch  | out | pos/norm xyz, corner_a..d, quad_valid
// One beat per cycle; the path runs through 24 division cells, five sine
// stages, a normal stage and a position stage that is the output register.
// A waiting output beat freezes the whole chain and drops in_ch.ready in the
// same cycle; bubbles inside the chain are not squeezed out while stalled.
// Reset clears valid flags and sets the configuration registers to their defaults.
// Top level of the UV sphere vertex generator; uses uvsph_pkg, uvsph_if,
// uvsph_core.
module uv_sphere_vertex_generator_top #(
	parameter int MAX_RINGS   = uvsph_pkg::MAX_RINGS_DEF,
	parameter int MAX_SECTORS = uvsph_pkg::MAX_SECTORS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	uvsph_if.sink       in_ch,
	uvsph_if.source     out_ch
);
	import uvsph_pkg::*;
	`include "assert_macros.svh"
	logic [15:0] radius_q;
	logic [8:0] rings_q, sectors_q, rings_c, sectors_c;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 16'd256;
			rings_q <= 9'd16;
			sectors_q <= 9'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RADIUS: radius_q <= cfg_data;
				REG_RINGS: rings_q <= cfg_data[8:0];
				REG_SECTORS: sectors_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		rings_c = (rings_q < 9'd2) ? 9'd2 :
			(rings_q > 9'(MAX_RINGS)) ? 9'(MAX_RINGS) : rings_q;
		sectors_c = (sectors_q < 9'd2) ? 9'd2 :
			(sectors_q > 9'(MAX_SECTORS)) ? 9'(MAX_SECTORS) : sectors_q;
	end
	logic en;
	cell_ctl_t ci, co;
	out_item_t res;
	assign en = !co.vld || out_ch.ready;
	assign in_ch.ready = en;
	always_comb begin
		ci.vld = in_ch.valid;
		ci.r = in_ch.data.ring_index;
		ci.s = in_ch.data.sector_index;
		ci.rd = 9'(rings_c - 9'd1);
		ci.sd = 9'(sectors_c - 9'd1);
		ci.sectors = sectors_c;
		ci.radius = radius_q;
	end
	uvsph_core u_core (.clk(clk), .arst_n(arst_n), .en(en), .ctl_in(ci),
		.ctl_out(co), .res(res));
	assign out_ch.valid = co.vld;
	assign out_ch.data = res;
	`ASSERT_IMPLIES(a_ready, clk, arst_n, co.vld && !out_ch.ready, !in_ch.ready)
	`ASSERT_NEXT(a_hold, clk, arst_n, co.vld && !out_ch.ready, co.vld)
	`ASSERT_IMPLIES(a_nq, clk, arst_n, co.vld && !res.quad_valid, res.corner_a == 16'd0)
endmodule

[bench/uv_sphere_vertex_generator_checker.sv]
// Checker for the UV sphere vertex generator: watches the input and output
// channels, predicts each vertex and compares. Uses uvsph_pkg and uvsph_if.
module uv_sphere_vertex_generator_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	uvsph_if             in_ch,
	uvsph_if             out_ch,
	output int           fail_count,
	output int           pending_count
);
	import uvsph_pkg::*;

	logic [15:0] radius;
	logic [8:0] rings_reg;
	logic [8:0] sectors_reg;
	out_item_t vertex_queue[$];

	assign pending_count = vertex_queue.size();

	function automatic longint quarter_sine(longint t);
		longint t2, inner, mid;
		t2 = (t * t) >>> 14;
		inner = 42047 - ((t2 * 4639) >>> 14);
		mid = 102944 - ((t2 * inner) >>> 14);
		return (t * mid) >>> 16;
	endfunction

	function automatic longint phase_sine(logic [15:0] p);
		longint f, v;
		f = p[13:0];
		v = p[14] ? quarter_sine(16384 - f) : quarter_sine(f);
		return p[15] ? -v : v;
	endfunction

	// Arithmetic shift right with rounding half up.
	function automatic longint round_shift(longint v, int sh);
		return (v + (longint'(1) << (sh - 1))) >>> sh;
	endfunction

	function automatic int clamp_count(logic [8:0] c);
		if (c < 2)
			return 2;
		if (c > 256)
			return 256;
		return c;
	endfunction

	function automatic out_item_t predict_vertex(in_item_t it);
		out_item_t o;
		int nr, ns, rd, sd, r, s;
		logic [15:0] pol, az;
		longint sp, cp, sa, ca;
		longint n[3];
		longint p;
		nr = clamp_count(rings_reg);
		ns = clamp_count(sectors_reg);
		rd = nr - 1;
		sd = ns - 1;
		r = it.ring_index;
		s = it.sector_index;
		pol = 16'((r * 32768 + rd / 2) / rd);
		az = 16'((s * 65536 + sd / 2) / sd);
		sp = phase_sine(pol);
		cp = phase_sine(pol + 16'd16384);
		sa = phase_sine(az);
		ca = phase_sine(az + 16'd16384);
		n[0] = round_shift(ca * sp, 14);
		n[1] = -cp;
		n[2] = round_shift(sa * sp, 14);
		o = '0;
		p = round_shift(n[0] * radius, 8);
		o.pos_x = p[23:0];
		p = round_shift(n[1] * radius, 8);
		o.pos_y = p[23:0];
		p = round_shift(n[2] * radius, 8);
		o.pos_z = p[23:0];
		o.norm_x = n[0][15:0];
		o.norm_y = n[1][15:0];
		o.norm_z = n[2][15:0];
		if (r < nr - 1 && s < ns - 1) begin
			o.corner_a = 16'(r * ns + s);
			o.corner_b = 16'(r * ns + s + 1);
			o.corner_c = 16'((r + 1) * ns + s + 1);
			o.corner_d = 16'((r + 1) * ns + s);
			o.quad_valid = 1'b1;
		end
		return o;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius <= 16'd256;
			rings_reg <= 9'd16;
			sectors_reg <= 9'd16;
			fail_count = 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				vertex_queue.push_back(predict_vertex(in_ch.data));
			if (out_ch.valid && out_ch.ready) begin
				if (vertex_queue.size() == 0) begin
					report("unexpected beat", 0, 0);
				end else begin
					out_item_t got, want;
					got = out_ch.data;
					want = vertex_queue.pop_front();
					if (got.pos_x !== want.pos_x) report("pos_x", got.pos_x, want.pos_x);
					if (got.pos_y !== want.pos_y) report("pos_y", got.pos_y, want.pos_y);
					if (got.pos_z !== want.pos_z) report("pos_z", got.pos_z, want.pos_z);
					if (got.norm_x !== want.norm_x) report("norm_x", got.norm_x, want.norm_x);
					if (got.norm_y !== want.norm_y) report("norm_y", got.norm_y, want.norm_y);
					if (got.norm_z !== want.norm_z) report("norm_z", got.norm_z, want.norm_z);
					if (got.corner_a !== want.corner_a)
						report("corner_a", got.corner_a, want.corner_a);
					if (got.corner_b !== want.corner_b)
						report("corner_b", got.corner_b, want.corner_b);
					if (got.corner_c !== want.corner_c)
						report("corner_c", got.corner_c, want.corner_c);
					if (got.corner_d !== want.corner_d)
						report("corner_d", got.corner_d, want.corner_d);
					if (got.quad_valid !== want.quad_valid)
						report("quad_valid", got.quad_valid, want.quad_valid);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_RADIUS: radius <= cfg_data;
					REG_RINGS: rings_reg <= cfg_data[8:0];
					REG_SECTORS: sectors_reg <= cfg_data[8:0];
					default: ;
				endcase
			end
		end
	end
endmodule

[bench/uv_sphere_vertex_generator_top_tb.sv]
// Testbench top for the UV sphere vertex generator: drives grid points and
// register writes, gives the verdict. Uses uvsph_pkg, uvsph_if and the checker.
module uv_sphere_vertex_generator_top_tb;
	import uvsph_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	int fail_count;
	int pending_count;
	int cycle_count = 0;
	int sink_idle = 0;
	bit idling_on = 1'b1;
	int nr = 16, ns = 16;

	uvsph_if #(.T(in_item_t)) in_ch ();
	uvsph_if #(.T(out_item_t)) out_ch ();

	uv_sphere_vertex_generator_top DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	uv_sphere_vertex_generator_checker checker_inst (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Output stalls come in bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			sink_idle <= 0;
		end else if (sink_idle > 0) begin
			sink_idle <= sink_idle - 1;
			out_ch.ready <= 1'b0;
		end else if (idling_on && $urandom_range(0, 15) == 0) begin
			sink_idle <= $urandom_range(1, 17) - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	task automatic send_point(logic [7:0] r, logic [7:0] s);
		in_item_t it;
		if (idling_on && $urandom_range(0, 11) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		it.ring_index = r;
		it.sector_index = s;
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] value);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic int clamp_count(int c);
		return c < 2 ? 2 : (c > 256 ? 256 : c);
	endfunction

	// Mostly points inside the grid, some past the counts.
	task automatic random_points(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 7) == 0)
				send_point($urandom_range(0, 255), $urandom_range(0, 255));
			else
				send_point($urandom_range(0, nr - 1), $urandom_range(0, ns - 1));
		end
	endtask

	task automatic set_grid(int radius, int rings, int sectors);
		write_reg(REG_RADIUS, radius[15:0]);
		write_reg(REG_RINGS, rings[15:0]);
		write_reg(REG_SECTORS, sectors[15:0]);
		nr = clamp_count(rings[8:0]);
		ns = clamp_count(sectors[8:0]);
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: poles, equator, last ring and sector, indices past counts.
		send_point(0, 0);
		send_point(15, 15);
		send_point(7, 4);
		send_point(14, 14);
		send_point(15, 0);
		send_point(0, 15);
		send_point(255, 255);
		send_point(16, 3);
		send_point(3, 200);
		send_point(8'haa, 8'h55);
		send_point(8'h55, 8'haa);
		set_grid(65535, 0, 1);
		send_point(0, 0);
		send_point(1, 1);
		send_point(255, 0);
		set_grid(0, 511, 300);
		send_point(254, 254);
		send_point(255, 255);
		send_point(128, 64);
		write_reg(reg_idx_t'(2'd3), 16'hffff);
		send_point(100, 100);

		set_grid(256, 16, 16);
		random_points(200);
		set_grid($urandom_range(0, 65535), $urandom_range(2, 40), $urandom_range(2, 40));
		random_points(200);
		set_grid(65535, 256, 256);
		random_points(200);
		set_grid(1, 2, 256);
		random_points(150);
		set_grid($urandom_range(0, 65535), $urandom_range(0, 511), $urandom_range(0, 511));
		random_points(200);
		idling_on = 1'b0;
		set_grid($urandom_range(0, 65535), 3, 7);
		random_points(280);

		in_ch.valid <= 1'b0;
		while (pending_count != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 8) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
